// ----- hw/rtl/twd_pkg.sv -----
// Types, constants and helper functions shared by the tile writeout dither block.
package twd_pkg;

	// Field widths fixed by the pixel and write formats
	localparam int ADDR_W   = 24;
	localparam int DATA_W   = 32;
	localparam int TILE_W   = 6;
	localparam int POS_W    = 5;
	localparam int STRIDE_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PACK_MODE   = 2'd2;

	// Pack modes
	localparam logic PACK_RGB565 = 1'b0;
	localparam logic PACK_RGBA32 = 1'b1;

	// Quantizer level counts
	localparam logic [5:0] LEVELS_5 = 6'd31;
	localparam logic [5:0] LEVELS_6 = 6'd63;

	// 4x4 ordered dither bias, indexed by {y[1:0], x[1:0]}
	localparam logic [7:0] BAYER_BIAS [0:15] = '{
		8'd8,   8'd136, 8'd40,  8'd168,
		8'd200, 8'd72,  8'd232, 8'd104,
		8'd56,  8'd184, 8'd24,  8'd152,
		8'd248, 8'd120, 8'd216, 8'd88
	};

	// One input pixel word
	typedef struct packed {
		logic [TILE_W-1:0] tile_col;
		logic [TILE_W-1:0] tile_row;
		logic [POS_W-1:0]  pix_x;
		logic [POS_W-1:0]  pix_y;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [7:0]        alpha;
	} pix_t;

	// One framebuffer write word
	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_data;
		logic              half_word;
	} wr_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [ADDR_W-1:0]   frame_base;
		logic [STRIDE_W-1:0] line_stride;
		logic                pack_mode;
	} cfg_t;

	// (c*levels + bias) / 255 with saturation at levels.
	// Divide by 255 as (x + (x >> 8) + 1) >> 8, exact for x below 65535.
	function automatic logic [5:0] quantize(input logic [7:0] c, input logic [5:0] levels,
		input logic [7:0] bias);
		logic [13:0] scaled;
		logic [14:0] sum;
		logic [6:0]  q;
		scaled = 14'(c) * 14'(levels) + 14'(bias);
		sum    = 15'(scaled) + 15'(scaled >> 8) + 15'd1;
		q      = sum[14:8];
		return (q > 7'(levels)) ? levels : q[5:0];
	endfunction

endpackage

// ----- hw/rtl/twd_calc.sv -----
// Combinational address and pixel packing for one tile pixel.
module twd_calc #(
	parameter int TILE_SIZE = 32
) (
	input  twd_pkg::pix_t pix,
	input  twd_pkg::cfg_t cfg,
	output twd_pkg::wr_t  res
);

	// Line and column index in the framebuffer
	localparam int IDX_W  = $clog2(63 * TILE_SIZE + 32);
	localparam int PROD_W = IDX_W + twd_pkg::STRIDE_W;

	logic [IDX_W-1:0]  line_idx;
	logic [IDX_W-1:0]  col_idx;
	logic [PROD_W-1:0] row_prod;
	logic [twd_pkg::ADDR_W-1:0] row_bytes;
	logic [twd_pkg::ADDR_W-1:0] col_bytes;
	logic [7:0] bias;
	logic [5:0] r_q;
	logic [5:0] g_q;
	logic [5:0] b_q;

	// Form line and column positions
	assign line_idx = IDX_W'(pix.tile_row) * IDX_W'(TILE_SIZE) + IDX_W'(pix.pix_y);
	assign col_idx  = IDX_W'(pix.tile_col) * IDX_W'(TILE_SIZE) + IDX_W'(pix.pix_x);

	// Byte offsets: stride is in units of 8 bytes, pixels are 2 or 4 bytes
	assign row_prod  = PROD_W'(line_idx) * PROD_W'(cfg.line_stride);
	assign row_bytes = twd_pkg::ADDR_W'({row_prod, 3'b000});
	assign col_bytes = (cfg.pack_mode == twd_pkg::PACK_RGBA32) ?
		twd_pkg::ADDR_W'({col_idx, 2'b00}) : twd_pkg::ADDR_W'({col_idx, 1'b0});

	// Dither and quantize each channel
	assign bias = twd_pkg::BAYER_BIAS[{pix.pix_y[1:0], pix.pix_x[1:0]}];
	assign r_q  = twd_pkg::quantize(pix.red,   twd_pkg::LEVELS_5, bias);
	assign g_q  = twd_pkg::quantize(pix.green, twd_pkg::LEVELS_6, bias);
	assign b_q  = twd_pkg::quantize(pix.blue,  twd_pkg::LEVELS_5, bias);

	// Sum the address (wraps at 24 bits) and pack as 565 or as little-endian RGBA bytes
	always_comb begin
		res.write_address = cfg.frame_base + row_bytes + col_bytes;
		if (cfg.pack_mode == twd_pkg::PACK_RGBA32) begin
			res.write_data = {pix.alpha, pix.blue, pix.green, pix.red};
			res.half_word  = 1'b0;
		end else begin
			res.write_data = {16'd0, b_q[4:0], g_q, r_q[4:0]};
			res.half_word  = 1'b1;
		end
	end

endmodule

// ----- hw/rtl/tile_writeout_dither_rgb565_core.sv -----
// Top level of the tile writeout block: pixel word in, framebuffer write word out.
//
// Usage:
//   pix channel (pix_valid/pix_ready/pix) carries one tile pixel word: tile
//   coordinates, position inside the tile and RGBA bytes.
//   wr channel (wr_valid/wr_ready/wr) carries one framebuffer write word per
//   pixel: byte address, packed data and a half_word flag (1 = 16-bit write).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes frame_base
//   (index 0), line_stride (index 1) and pack_mode (index 2); other indexes are
//   dropped. cfg_ready is always high. Write configuration only while idle.
//   wr_valid rises once an accepted word has moved through the input register
//   and the output register; the address multiply-add and the dither
//   quantizers sit between input and output register. Throughput is one word
//   per cycle while wr_ready is high: each register advances when the next is free.
//   When the receiver stalls, the output register holds and the input
//   register still fills, so up to two words wait inside before pix_ready
//   drops. Reset clears both valid flags and sets the configuration registers
//   to 0 (RGB565 mode, base 0, stride 0).
module tile_writeout_dither_rgb565_core #(
	parameter int TILE_SIZE = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  twd_pkg::pix_t                      pix,
	output logic                               wr_valid,
	input  logic                               wr_ready,
	output twd_pkg::wr_t                       wr,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [twd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [twd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	twd_pkg::cfg_t cfg_q;
	twd_pkg::pix_t pix_s1;
	twd_pkg::wr_t  wr_s2;
	twd_pkg::wr_t  res;
	logic          v_s1;
	logic          v_s2;
	logic          adv_s2;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base  <= '0;
			cfg_q.line_stride <= '0;
			cfg_q.pack_mode   <= twd_pkg::PACK_RGB565;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				twd_pkg::CFG_FRAME_BASE: begin
					cfg_q.frame_base <= cfg_data[twd_pkg::ADDR_W-1:0];
				end
				twd_pkg::CFG_LINE_STRIDE: begin
					cfg_q.line_stride <= cfg_data[twd_pkg::STRIDE_W-1:0];
				end
				twd_pkg::CFG_PACK_MODE: begin
					cfg_q.pack_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Advance when the output register is empty or being drained
	assign adv_s2    = !v_s2 || wr_ready;
	assign pix_ready = !v_s1 || adv_s2;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (pix_ready) begin
				v_s1 <= pix_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Input register: capture the accepted word
	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_s1 <= pix;
		end
	end

	twd_calc #(
		.TILE_SIZE(TILE_SIZE)
	) u_calc (
		.pix(pix_s1),
		.cfg(cfg_q),
		.res(res)
	);

	// Output register: load the result when it can move forward
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			wr_s2 <= res;
		end
	end

	assign wr_valid = v_s2;
	assign wr       = wr_s2;

`ifndef SYNTHESIS
	// A 16-bit write carries zeros in the upper half
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid && wr.half_word) |-> (wr.write_data[31:16] == 16'd0))
		else $error("upper half of a 16-bit write word is not zero");

	// A stalled input stage keeps its word
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s2) |=> (v_s1 && $stable(pix_s1)))
		else $error("input stage lost or changed a stalled word");

	// An output word only appears after the input stage held one
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wr_valid) |-> $past(v_s1))
		else $error("output word appeared without an input word");
`endif

endmodule

// ----- tb/writeout_checker.sv -----
// Checker for the tile writeout block: predicts each framebuffer write and compares it.
`timescale 1ns / 1ps

module writeout_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	input  logic                           pix_ready,
	input  twd_pkg::pix_t                  pix,
	input  logic                           wr_valid,
	input  logic                           wr_ready,
	input  twd_pkg::wr_t                   wr,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [twd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [twd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);

	localparam int unsigned TILE_PIXELS = 32;

	// Ordered dither thresholds, row by pixel row mod 4, column by pixel column mod 4
	localparam int unsigned DITHER_BIAS [4][4] = '{
		'{  8, 136,  40, 168},
		'{200,  72, 232, 104},
		'{ 56, 184,  24, 152},
		'{248, 120, 216,  88}
	};

	// Shadow copy of the block's registers
	logic [twd_pkg::ADDR_W-1:0]   frame_base_q;
	logic [twd_pkg::STRIDE_W-1:0] line_stride_q;
	logic                         pack_mode_q;

	twd_pkg::wr_t expected_writes [$];
	int           fail_n;

	// Scale a byte to a level count with a dither bias, saturating at the top level
	function automatic logic [5:0] dither_level(input int unsigned c, input int unsigned levels,
		input int unsigned bias);
		int unsigned q;
		q = (c * levels + bias) / 255;
		return (q > levels) ? levels[5:0] : q[5:0];
	endfunction

	// Framebuffer write that one pixel word should produce under the current registers
	function automatic twd_pkg::wr_t predict_write(input twd_pkg::pix_t p);
		twd_pkg::wr_t    w;
		logic [63:0]     addr_sum;
		longint unsigned bpp;
		longint unsigned line_bytes;
		int unsigned     bias;
		bpp        = (pack_mode_q == twd_pkg::PACK_RGBA32) ? 4 : 2;
		line_bytes = longint'(line_stride_q) * 8;
		addr_sum   = longint'(frame_base_q)
			+ longint'(p.tile_col) * TILE_PIXELS * bpp
			+ longint'(p.tile_row) * TILE_PIXELS * line_bytes
			+ longint'(p.pix_y) * line_bytes
			+ longint'(p.pix_x) * bpp;
		w.write_address = addr_sum[twd_pkg::ADDR_W-1:0];
		if (pack_mode_q == twd_pkg::PACK_RGB565) begin
			bias = DITHER_BIAS[p.pix_y[1:0]][p.pix_x[1:0]];
			w.write_data = '0;
			w.write_data[4:0]   = 5'(dither_level(int'(p.red), 31, bias));
			w.write_data[10:5]  = dither_level(int'(p.green), 63, bias);
			w.write_data[15:11] = 5'(dither_level(int'(p.blue), 31, bias));
			w.half_word = 1'b1;
		end else begin
			w.write_data = {p.alpha, p.blue, p.green, p.red};
			w.half_word  = 1'b0;
		end
		return w;
	endfunction

	// Track registers, queue predictions and compare write words
	always @(posedge clk or negedge arst_n) begin : watch
		twd_pkg::wr_t want;
		if (!arst_n) begin
			expected_writes.delete();
			frame_base_q  = '0;
			line_stride_q = '0;
			pack_mode_q   = twd_pkg::PACK_RGB565;
			fail_n        = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					twd_pkg::CFG_FRAME_BASE:
						frame_base_q  = cfg_data[twd_pkg::ADDR_W-1:0];
					twd_pkg::CFG_LINE_STRIDE:
						line_stride_q = cfg_data[twd_pkg::STRIDE_W-1:0];
					twd_pkg::CFG_PACK_MODE:
						pack_mode_q   = cfg_data[0];
					default: ;
				endcase
			end
			// Retire the oldest prediction before queuing this edge's pixel
			if (wr_valid && wr_ready) begin
				if (expected_writes.size() == 0) begin
					$error("write word with no pixel pending: address %h data %h",
						wr.write_address, wr.write_data);
					fail_n++;
				end else begin
					want = expected_writes.pop_front();
					if (wr.write_address !== want.write_address) begin
						$error("write_address expected %h, got %h",
							want.write_address, wr.write_address);
						fail_n++;
					end
					if (wr.write_data !== want.write_data) begin
						$error("write_data expected %h, got %h", want.write_data, wr.write_data);
						fail_n++;
					end
					if (wr.half_word !== want.half_word) begin
						$error("half_word expected %b, got %b", want.half_word, wr.half_word);
						fail_n++;
					end
				end
			end
			if (pix_valid && pix_ready)
				expected_writes.push_back(predict_write(pix));
			errors  <= fail_n;
			pending <= expected_writes.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the tile writeout testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_PER_PHASE = 194;
	localparam int PHASES           = 8;
	localparam int HOLD_CYCLES      = 80;
	localparam int DRAIN_CYCLES     = 6;
	localparam int TIMEOUT_NS       = 2_000_000;
	localparam logic [twd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           pix_valid;
	logic                           pix_ready;
	twd_pkg::pix_t                  pix;
	logic                           wr_valid;
	logic                           wr_ready;
	twd_pkg::wr_t                   wr;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [twd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [twd_pkg::CFG_DATA_W-1:0] cfg_data;
	int                             errors;
	int                             pending;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int hold_served;
	int words_sent;
	int settings_used;

	tile_writeout_dither_rgb565_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	writeout_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("tile_writeout_dither_rgb565_core verification failed");
		$finish;
	end

	// Write sink: random stalls, plus a long hold-off on request
	initial begin : receiver
		wr_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_served != hold_req) begin
				wr_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_served++;
			end else begin
				wr_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic twd_pkg::pix_t make_pixel(input int col, input int row, input int x,
		input int y, input int r, input int g, input int b, input int a);
		twd_pkg::pix_t p;
		p.tile_col = col[twd_pkg::TILE_W-1:0];
		p.tile_row = row[twd_pkg::TILE_W-1:0];
		p.pix_x    = x[twd_pkg::POS_W-1:0];
		p.pix_y    = y[twd_pkg::POS_W-1:0];
		p.red      = r[7:0];
		p.green    = g[7:0];
		p.blue     = b[7:0];
		p.alpha    = a[7:0];
		return p;
	endfunction

	// Color byte leaning toward the quantizer extremes now and then
	function automatic logic [7:0] random_channel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic twd_pkg::pix_t random_pixel();
		twd_pkg::pix_t p;
		p.tile_col = twd_pkg::TILE_W'($urandom);
		p.tile_row = twd_pkg::TILE_W'($urandom);
		p.pix_x    = twd_pkg::POS_W'($urandom);
		p.pix_y    = twd_pkg::POS_W'($urandom);
		p.red      = random_channel();
		p.green    = random_channel();
		p.blue     = random_channel();
		p.alpha    = random_channel();
		return p;
	endfunction

	// Offer one pixel word after a random gap, hold until accepted
	task automatic send_pixel(input twd_pkg::pix_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (!pix_ready);
		words_sent++;
	endtask

	// Write all registers back to back; junk sits in the unused bits and index
	task automatic apply_setting(input logic [twd_pkg::ADDR_W-1:0] base,
		input logic [twd_pkg::STRIDE_W-1:0] stride, input logic mode);
		logic [twd_pkg::CFG_DATA_W-1:0] junk;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_UNUSED;
		cfg_data  <= twd_pkg::CFG_DATA_W'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= twd_pkg::CFG_FRAME_BASE;
		cfg_data  <= base;
		do @(posedge clk); while (!cfg_ready);
		junk = twd_pkg::CFG_DATA_W'($urandom);
		junk[twd_pkg::STRIDE_W-1:0] = stride;
		cfg_index <= twd_pkg::CFG_LINE_STRIDE;
		cfg_data  <= junk;
		do @(posedge clk); while (!cfg_ready);
		junk = twd_pkg::CFG_DATA_W'($urandom);
		junk[0] = mode;
		cfg_index <= twd_pkg::CFG_PACK_MODE;
		cfg_data  <= junk;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Drop valid and wait until every predicted write has come back
	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [twd_pkg::ADDR_W-1:0]   base;
		logic [twd_pkg::STRIDE_W-1:0] stride;
		int directed_n;
		arst_n    <= 1'b0;
		pix_valid <= 1'b0;
		pix       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= twd_pkg::CFG_FRAME_BASE;
		cfg_data  <= '0;
		send_idle_pct = 25;
		recv_idle_pct = 54;
		hold_req      = 0;
		hold_served   = 0;
		words_sent    = 0;
		settings_used = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Dithered mode: every threshold position, color ramps, address wrap near the top
		apply_setting(24'hFFFFF0, 9'd511, twd_pkg::PACK_RGB565);
		for (int i = 0; i < 16; i++)
			send_pixel(make_pixel(i * 4, 63 - i * 4, (i % 4) + 4 * (i / 4), (i / 4) + 8 * (i % 4),
				i * 17, 255 - i * 17, (i % 2) ? 255 : 0, 8'hA5));
		send_pixel(make_pixel(63, 63, 31, 31, 255, 255, 255, 255));
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
		drain();

		// Packed mode: extremes and a byte-order pattern
		apply_setting(24'hFFFFFF, 9'd511, twd_pkg::PACK_RGBA32);
		send_pixel(make_pixel(63, 63, 31, 31, 255, 255, 255, 255));
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(42, 21, 21, 10, 8'h01, 8'h02, 8'h03, 8'h04));
		send_pixel(make_pixel(21, 42, 10, 21, 8'h80, 8'h7F, 8'hC3, 8'h3C));
		drain();
		directed_n = words_sent;

		// Random phases, register settings alternating extremes and random values
		for (int phase_n = 0; phase_n < PHASES; phase_n++) begin
			if (phase_n < 3) begin
				send_idle_pct = 25;
				recv_idle_pct = 54;
			end else if (phase_n < 6) begin
				send_idle_pct = 54;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase_n == 0 || phase_n == 5)
				base = '0;
			else if (phase_n == 1 || phase_n == 4)
				base = '1;
			else
				base = twd_pkg::ADDR_W'($urandom);
			if (phase_n == 0 || phase_n == 4)
				stride = '0;
			else if (phase_n == 1 || phase_n == 5)
				stride = '1;
			else
				stride = twd_pkg::STRIDE_W'($urandom);
			apply_setting(base, stride,
				(phase_n % 2) ? twd_pkg::PACK_RGBA32 : twd_pkg::PACK_RGB565);
			// Stall the sink long enough to back the pipe up into the input
			if (phase_n == 6)
				hold_req++;
			repeat (RANDOM_PER_PHASE) send_pixel(random_pixel());
			drain();
		end

		$display("Covered %0d pixel words (%0d directed) over %0d register settings,",
			words_sent, directed_n, settings_used);
		$display("both pack modes, random stalls on both sides and a %0d-cycle sink hold-off.",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("tile_writeout_dither_rgb565_core verification clean");
		else
			$display("tile_writeout_dither_rgb565_core verification failed");
		$finish;
	end

endmodule

// ----- tile_writeout_dither_rgb565_core.f -----
hw/rtl/twd_pkg.sv
hw/rtl/twd_calc.sv
hw/rtl/tile_writeout_dither_rgb565_core.sv
tb/writeout_checker.sv
tb/testbench.sv
